// ===== hw/rtl/text_console_cursor_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Text console cursor engine - assertion macros
// Shared property forms for the engine's modules. Each module that uses
// them has signals named clk and rst.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine - package
// Geometry, field widths, character codes, state and command types shared
// by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

  // Storage and counter widths.
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int TAB_W  = $clog2(TAB_WIDTH + 1);
  localparam int CELL_W = 16;
  localparam int LIN_W  = 16;

  // Field widths.
  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int START_W  = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CADDR_W  = 11;
  localparam int ATTR_W   = 8;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_TEXT_ATTR = '0;

  // Character codes.
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_LO     = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_HI     = 8'd126;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_SPARE = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    OPC_PRINT,
    OPC_BACK,
    OPC_TAB,
    OPC_NEWLINE,
    OPC_RETURN,
    OPC_READ,
    OPC_CLEAR,
    OPC_PLACE,
    OPC_NOP
  } op_class_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_TAB,
    S_READ,
    S_COPY,
    S_BLANK,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CHAR,
    WR_RESET_BLANK,
    WR_BLANK,
    WR_COPY
  } wr_mode_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_CELL,
    RD_COPY
  } rd_mode_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADVANCE,
    CUR_BACK,
    CUR_NEWLINE,
    CUR_RETURN,
    CUR_HOME,
    CUR_PLACE
  } cur_op_t;

  // Controller to datapath.
  typedef struct packed {
    logic     take_item;
    logic     cnt_clear;
    logic     cnt_inc;
    wr_mode_t wr_mode;
    rd_mode_t rd_mode;
    cur_op_t  cur_op;
    logic     tab_load;
    logic     tab_dec;
    logic     scroll_set;
    logic     read_capture;
    logic     load_out;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_class_t op_class;
    logic      wrap_last;
    logic      row_last;
    logic      tab_last;
    logic      tab_zero;
    logic      copy_end;
    logic      fill_end;
  } dp_stat_t;

  // Number of cursor steps a tab takes from each column.
  typedef logic [TAB_W-1:0] tab_tbl_t [0:(1 << COL_W) - 1];

  function automatic tab_tbl_t build_tab_tbl();
    tab_tbl_t tbl;
    for (int i = 0; i < (1 << COL_W); i++) begin
      tbl[i] = TAB_W'(TAB_WIDTH - (i % TAB_WIDTH));
    end
    return tbl;
  endfunction

  localparam tab_tbl_t TAB_SPAN = build_tab_tbl();

endpackage

// ===== hw/rtl/tcce_in_if.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine - request channel
// Valid/ready channel that carries one console request.
// ----------------------------------------------------------------------------
interface tcce_in_if;
  import tcce_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CHAR_W-1:0]   char_code;
  logic [INDEX_W-1:0]  cell_index;
  logic [START_W-1:0]  start_col;
  logic [START_W-1:0]  start_row;

  modport source (
    output valid, opcode, char_code, cell_index, start_col, start_row,
    input  ready
  );

  modport sink (
    input  valid, opcode, char_code, cell_index, start_col, start_row,
    output ready
  );
endinterface

// ===== hw/rtl/tcce_out_if.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine - result channel
// Valid/ready channel that carries the cursor and cell result of a request.
// ----------------------------------------------------------------------------
interface tcce_out_if;
  import tcce_pkg::*;

  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   cursor_col;
  logic [ROW_W-1:0]   cursor_row;
  logic [CADDR_W-1:0] cursor_address;
  logic [CHAR_W-1:0]  cell_char;
  logic [ATTR_W-1:0]  cell_attr;
  logic               scrolled;

  modport source (
    output valid, cursor_col, cursor_row, cursor_address, cell_char, cell_attr,
           scrolled,
    input  ready
  );

  modport sink (
    input  valid, cursor_col, cursor_row, cursor_address, cell_char, cell_attr,
           scrolled,
    output ready
  );
endinterface

// ===== hw/rtl/tcce_dpath.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine - datapath
// Cell store, cursor, sweep counter, tab counter, request latch and the
// result register. Acts only on controller commands and configuration writes.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_assert.svh"

module tcce_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  tcce_pkg::dp_cmd_t            cmd,
  output tcce_pkg::dp_stat_t           stat,
  input  logic [tcce_pkg::OPCODE_W-1:0] opcode,
  input  logic [tcce_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcce_pkg::INDEX_W-1:0] cell_index,
  input  logic [tcce_pkg::START_W-1:0] start_col,
  input  logic [tcce_pkg::START_W-1:0] start_row,
  input  logic                         cfg_we,
  input  logic [tcce_pkg::ATTR_W-1:0]  cfg_data,
  output logic [tcce_pkg::ATTR_W-1:0]  text_attr,
  output logic [tcce_pkg::COL_W-1:0]   cursor_col,
  output logic [tcce_pkg::ROW_W-1:0]   cursor_row,
  output logic [tcce_pkg::CADDR_W-1:0] cursor_address,
  output logic [tcce_pkg::CHAR_W-1:0]  cell_char,
  output logic [tcce_pkg::ATTR_W-1:0]  cell_attr,
  output logic                         scrolled
);
  import tcce_pkg::*;

  logic [OPCODE_W-1:0] item_op;
  logic [CHAR_W-1:0]   item_char;
  logic [INDEX_W-1:0]  item_index;
  logic [START_W-1:0]  item_scol;
  logic [START_W-1:0]  item_srow;
  op_class_t           op_class;

  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  logic [TAB_W-1:0] tab_left;
  logic [CNT_W-1:0] cnt;

  logic [LIN_W-1:0] cur_lin;
  logic [LIN_W-1:0] copy_src;
  logic             col_last;
  logic             row_last;
  logic             idx_ok;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;

  logic [CHAR_W-1:0] res_char;
  logic [ATTR_W-1:0] res_attr;
  logic              res_scrolled;

  assign cur_lin  = LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
  assign copy_src = LIN_W'(cnt) + LIN_W'(COLUMNS);
  assign col_last = (col == COL_W'(COLUMNS - 1));
  assign row_last = (row == ROW_W'(ROWS - 1));
  assign idx_ok   = (LIN_W'(item_index) < LIN_W'(CELL_COUNT));

  // Classify the latched request.
  always_comb begin
    op_class = OPC_NOP;
    case (opcode_t'(item_op))
      OP_PUT: begin
        if (item_char inside {[PRINT_LO:PRINT_HI]}) begin
          op_class = OPC_PRINT;
        end else begin
          case (item_char)
            CH_BACKSPACE: op_class = OPC_BACK;
            CH_TAB:       op_class = OPC_TAB;
            CH_NEWLINE:   op_class = OPC_NEWLINE;
            CH_RETURN:    op_class = OPC_RETURN;
            default:      op_class = OPC_NOP;
          endcase
        end
      end
      OP_READ: op_class = OPC_READ;
      OP_START: begin
        if ((item_scol >= START_W'(COLUMNS)) || (item_srow >= START_W'(ROWS)) ||
            ((item_scol == '0) && (item_srow == '0))) begin
          op_class = OPC_CLEAR;
        end else begin
          op_class = OPC_PLACE;
        end
      end
      default: op_class = OPC_NOP;
    endcase
  end

  assign stat.op_class  = op_class;
  assign stat.wrap_last = col_last && row_last;
  assign stat.row_last  = row_last;
  assign stat.tab_last  = (tab_left == TAB_W'(1));
  assign stat.tab_zero  = (tab_left == '0);
  assign stat.copy_end  = (cnt == CNT_W'(COPY_COUNT));
  assign stat.fill_end  = (cnt == CNT_W'(CELL_COUNT - 1));

  // Cursor update. At the last row the row saturates; the scroll sweep
  // moves the text up underneath it.
  always_comb begin
    col_next = col;
    row_next = row;
    case (cmd.cur_op)
      CUR_ADVANCE: begin
        if (col_last) begin
          col_next = '0;
          if (!row_last) begin
            row_next = row + ROW_W'(1);
          end
        end else begin
          col_next = col + COL_W'(1);
        end
      end
      CUR_BACK: begin
        if (col != '0) begin
          col_next = col - COL_W'(1);
        end
      end
      CUR_NEWLINE: begin
        col_next = '0;
        if (!row_last) begin
          row_next = row + ROW_W'(1);
        end
      end
      CUR_RETURN: col_next = '0;
      CUR_HOME: begin
        col_next = '0;
        row_next = '0;
      end
      CUR_PLACE: begin
        col_next = item_scol[COL_W-1:0];
        row_next = item_srow[ROW_W-1:0];
      end
      default: begin
        col_next = col;
        row_next = row;
      end
    endcase
  end

  // Store write port.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt[ADDR_W-1:0];
    wr_data = {text_attr, BLANK_CHAR};
    case (cmd.wr_mode)
      WR_CHAR: begin
        wr_en   = 1'b1;
        wr_addr = cur_lin[ADDR_W-1:0];
        wr_data = {text_attr, item_char};
      end
      WR_RESET_BLANK: begin
        wr_en   = 1'b1;
        wr_data = {RESET_ATTR, BLANK_CHAR};
      end
      WR_BLANK: wr_en = 1'b1;
      WR_COPY: begin
        // The read issued in the previous cycle lands one row up.
        wr_en   = (cnt != '0);
        wr_addr = ADDR_W'(cnt - CNT_W'(1));
        wr_data = rd_data;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Store read port.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (cmd.rd_mode)
      RD_CELL: begin
        rd_en   = 1'b1;
        rd_addr = idx_ok ? ADDR_W'(item_index) : '0;
      end
      RD_COPY: begin
        rd_en   = (cnt < CNT_W'(COPY_COUNT));
        rd_addr = copy_src[ADDR_W-1:0];
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      tab_left  <= '0;
      cnt       <= '0;
      text_attr <= RESET_ATTR;
    end else begin
      col <= col_next;
      row <= row_next;
      if (cfg_we) begin
        text_attr <= cfg_data;
      end
      if (cmd.cnt_clear) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.take_item) begin
        tab_left <= '0;
      end else if (cmd.tab_load) begin
        tab_left <= TAB_SPAN[col];
      end else if (cmd.tab_dec) begin
        tab_left <= tab_left - TAB_W'(1);
      end
    end
  end

  // Request latch and result fields.
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_op      <= opcode;
      item_char    <= char_code;
      item_index   <= cell_index;
      item_scol    <= start_col;
      item_srow    <= start_row;
      res_char     <= '0;
      res_attr     <= '0;
      res_scrolled <= 1'b0;
    end else begin
      if (cmd.scroll_set) begin
        res_scrolled <= 1'b1;
      end
      if (cmd.read_capture) begin
        res_char <= idx_ok ? rd_data[CHAR_W-1:0] : '0;
        res_attr <= idx_ok ? rd_data[CELL_W-1:CHAR_W] : '0;
      end
    end
    if (cmd.load_out) begin
      cursor_col     <= col;
      cursor_row     <= row;
      cursor_address <= cur_lin[CADDR_W-1:0];
      cell_char      <= res_char;
      cell_attr      <= res_attr;
      scrolled       <= res_scrolled;
    end
  end

  `TCCE_ASSERT_IMPL(a_cursor_on_screen, 1'b1,
    (col < COL_W'(COLUMNS)) && (row < ROW_W'(ROWS)), "cursor is off the screen")
  `TCCE_ASSERT_IMPL(a_write_in_store, wr_en,
    LIN_W'(wr_addr) < LIN_W'(CELL_COUNT), "store write outside the cells")

endmodule

// ===== hw/rtl/tcce_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine - controller
// Sequences the store sweeps, tab steps and reads, and owns the request
// and result handshakes.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_assert.svh"

module tcce_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tcce_pkg::dp_cmd_t   cmd,
  input  tcce_pkg::dp_stat_t  stat
);
  import tcce_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_q;
  logic   accept;
  logic   slot_free;

  assign accept    = in_valid && (state == S_IDLE);
  assign slot_free = !out_valid_q || out_ready;
  assign out_valid = out_valid_q;

  always_comb begin
    state_next = state;
    case (state)
      S_INIT:  if (stat.fill_end) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC: begin
        case (stat.op_class)
          OPC_PRINT:   state_next = stat.wrap_last ? S_COPY : S_DONE;
          OPC_NEWLINE: state_next = stat.row_last ? S_COPY : S_DONE;
          OPC_TAB:     state_next = S_TAB;
          OPC_READ:    state_next = S_READ;
          OPC_CLEAR:   state_next = S_CLEAR;
          default:     state_next = S_DONE;
        endcase
      end
      S_TAB: begin
        if (stat.wrap_last) begin
          state_next = S_COPY;
        end else if (stat.tab_last) begin
          state_next = S_DONE;
        end
      end
      S_READ:  state_next = S_DONE;
      S_COPY:  if (stat.copy_end) state_next = S_BLANK;
      S_BLANK: if (stat.fill_end) state_next = stat.tab_zero ? S_DONE : S_TAB;
      S_CLEAR: if (stat.fill_end) state_next = S_DONE;
      S_DONE:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.wr_mode  = WR_NONE;
    cmd.rd_mode  = RD_NONE;
    cmd.cur_op   = CUR_HOLD;
    in_ready     = 1'b0;
    case (state)
      S_INIT: begin
        cmd.wr_mode = WR_RESET_BLANK;
        cmd.cnt_inc = 1'b1;
      end
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_item = in_valid;
      end
      S_EXEC: begin
        case (stat.op_class)
          OPC_PRINT: begin
            cmd.wr_mode    = WR_CHAR;
            cmd.cur_op     = CUR_ADVANCE;
            cmd.scroll_set = stat.wrap_last;
            cmd.cnt_clear  = 1'b1;
          end
          OPC_BACK:   cmd.cur_op = CUR_BACK;
          OPC_RETURN: cmd.cur_op = CUR_RETURN;
          OPC_NEWLINE: begin
            cmd.cur_op     = CUR_NEWLINE;
            cmd.scroll_set = stat.row_last;
            cmd.cnt_clear  = 1'b1;
          end
          OPC_TAB:  cmd.tab_load = 1'b1;
          OPC_READ: cmd.rd_mode = RD_CELL;
          OPC_CLEAR: begin
            cmd.cur_op     = CUR_HOME;
            cmd.scroll_set = 1'b1;
            cmd.cnt_clear  = 1'b1;
          end
          OPC_PLACE: cmd.cur_op = CUR_PLACE;
          default:   cmd.cur_op = CUR_HOLD;
        endcase
      end
      S_TAB: begin
        cmd.cur_op     = CUR_ADVANCE;
        cmd.tab_dec    = 1'b1;
        cmd.scroll_set = stat.wrap_last;
        cmd.cnt_clear  = 1'b1;
      end
      S_READ: cmd.read_capture = 1'b1;
      S_COPY: begin
        cmd.rd_mode = RD_COPY;
        cmd.wr_mode = WR_COPY;
        cmd.cnt_inc = !stat.copy_end;
      end
      S_BLANK, S_CLEAR: begin
        cmd.wr_mode = WR_BLANK;
        cmd.cnt_inc = 1'b1;
      end
      S_DONE:  cmd.load_out = slot_free;
      default: cmd.cur_op = CUR_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `TCCE_ASSERT_IMPL(a_load_into_free_slot, cmd.load_out,
    !out_valid_q || out_ready, "result loaded over an untaken result")
  `TCCE_ASSERT_NEXT(a_done_shows_result, (state == S_DONE) && (state_next == S_IDLE),
    out_valid_q, "finished request left no result")

endmodule

// ===== hw/rtl/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine - top level
// 80x25 text console: a store of character and attribute cells, a cursor,
// control-code handling, scrolling and screen clearing.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the item channel (valid/ready) and each one gives
//   exactly one result on the result channel, in order. The text attribute
//   is written through the APB-style port at address 0 by the user, who must
//   do so only while the engine is idle; the block itself does not enforce
//   this. prdata returns the attribute. Each request is accepted in idle,
//   executed, and its result loaded in the done state; a tab moves the
//   cursor one step at a time (at most TAB_WIDTH steps) and a cell read
//   first reads the store. The engine returns to idle for its next request
//   in the cycle after loading the result, and takes one request at a time.
//   A scroll copies the store one cell per cycle through its single write
//   port and then blanks the last row; a clear from the start request also
//   sweeps all 2000 cells, one per cycle.
//   After reset the engine fills the store with blanks in attribute 0x0F,
//   one cell per cycle; ready stays low until that sweep ends, while
//   configuration writes are taken throughout.
//   The result sits in an output register: a new request is accepted while
//   it waits, but that request's result is held back until the receiver has
//   taken the previous one.
// ----------------------------------------------------------------------------
module text_console_cursor_engine (
  input  logic                         clk,
  input  logic                         rst,
  tcce_in_if.sink                      item,
  tcce_out_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tcce_pkg::PADDR_W-1:0] paddr,
  input  logic [tcce_pkg::PDATA_W-1:0] pwdata,
  output logic [tcce_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import tcce_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic              cfg_sel;
  logic              cfg_we;
  logic [ATTR_W-1:0] text_attr;

  // Registers are word aligned; the byte offset bits are not decoded.
  assign cfg_sel = (paddr[PADDR_W-1:2] == REG_TEXT_ATTR);
  assign cfg_we  = psel && penable && pwrite && cfg_sel;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? PDATA_W'(text_attr) : '0;

  // The controller sequences every multi-cycle action; the datapath holds
  // the store, the cursor and the result register.
  tcce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tcce_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .opcode         (item.opcode),
    .char_code      (item.char_code),
    .cell_index     (item.cell_index),
    .start_col      (item.start_col),
    .start_row      (item.start_row),
    .cfg_we         (cfg_we),
    .cfg_data       (pwdata[ATTR_W-1:0]),
    .text_attr      (text_attr),
    .cursor_col     (result.cursor_col),
    .cursor_row     (result.cursor_row),
    .cursor_address (result.cursor_address),
    .cell_char      (result.cell_char),
    .cell_attr      (result.cell_attr),
    .scrolled       (result.scrolled)
  );

endmodule

// ===== test/tcce_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine - testbench scoreboard
// Request and result records, and a scoreboard that keeps its own copy of
// the screen, cursor and text attribute, works out the result of every
// accepted request and checks the results as they come back.
// ----------------------------------------------------------------------------
package tcce_tb_pkg;
  import tcce_pkg::*;

  typedef struct packed {
    opcode_t             opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;
    logic [START_W-1:0]  start_col;
    logic [START_W-1:0]  start_row;
  } console_req_t;

  typedef struct packed {
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic [CADDR_W-1:0] cursor_address;
    logic [CHAR_W-1:0]  cell_char;
    logic [ATTR_W-1:0]  cell_attr;
    logic               scrolled;
  } console_res_t;

  class console_scoreboard;
    logic [CELL_W-1:0] screen [CELL_COUNT];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [ATTR_W-1:0] attr;
    console_res_t      pending_q[$];
    int unsigned       errors;

    function new();
      attr = RESET_ATTR;
      foreach (screen[i]) screen[i] = {RESET_ATTR, BLANK_CHAR};
      cur_col = 0;
      cur_row = 0;
      errors  = 0;
    endfunction

    function void set_attr(logic [ATTR_W-1:0] value);
      attr = value;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void scroll_screen();
      for (int i = 0; i < COPY_COUNT; i++) screen[i] = screen[i + COLUMNS];
      for (int i = COPY_COUNT; i < CELL_COUNT; i++) screen[i] = {attr, BLANK_CHAR};
      cur_row = ROWS - 1;
      cur_col = 0;
    endfunction

    // Moves the cursor one cell on; returns 1 when that scrolled the screen.
    function bit step_cursor();
      cur_col++;
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
          scroll_screen();
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(console_req_t r);
      console_res_t res;
      int unsigned  span;
      res = '0;
      case (r.opcode)
        OP_PUT: begin
          if (r.char_code >= PRINT_LO && r.char_code <= PRINT_HI) begin
            screen[cur_row * COLUMNS + cur_col] = {attr, r.char_code};
            res.scrolled = step_cursor();
          end else if (r.char_code == CH_BACKSPACE) begin
            if (cur_col != 0) cur_col--;
          end else if (r.char_code == CH_TAB) begin
            span = TAB_WIDTH - (cur_col % TAB_WIDTH);
            repeat (span) if (step_cursor()) res.scrolled = 1'b1;
          end else if (r.char_code == CH_NEWLINE) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= ROWS) begin
              scroll_screen();
              res.scrolled = 1'b1;
            end
          end else if (r.char_code == CH_RETURN) begin
            cur_col = 0;
          end
        end
        OP_READ: begin
          if (r.cell_index < CELL_COUNT) {res.cell_attr, res.cell_char} = screen[r.cell_index];
        end
        OP_START: begin
          if (r.start_col >= COLUMNS || r.start_row >= ROWS ||
              (r.start_col == 0 && r.start_row == 0)) begin
            foreach (screen[i]) screen[i] = {attr, BLANK_CHAR};
            cur_col      = 0;
            cur_row      = 0;
            res.scrolled = 1'b1;
          end else begin
            cur_col = r.start_col;
            cur_row = r.start_row;
          end
        end
        default: ;
      endcase
      res.cursor_col     = COL_W'(cur_col);
      res.cursor_row     = ROW_W'(cur_row);
      res.cursor_address = CADDR_W'(cur_col + cur_row * COLUMNS);
      pending_q.push_back(res);
    endfunction

    task report(string what);
      errors++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task check_result(console_res_t got);
      console_res_t want;
      if (pending_q.size() == 0) begin
        report("result arrived with no request outstanding");
        return;
      end
      want = pending_q.pop_front();
      check_field("cursor_col", got.cursor_col, want.cursor_col);
      check_field("cursor_row", got.cursor_row, want.cursor_row);
      check_field("cursor_address", got.cursor_address, want.cursor_address);
      check_field("cell_char", got.cell_char, want.cell_char);
      check_field("cell_attr", got.cell_attr, want.cell_attr);
      check_field("scrolled", got.scrolled, want.scrolled);
    endtask
  endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor engine - testbench top level
// Drives console requests and APB writes of the text attribute, mirrors the
// screen and cursor in a scoreboard, and checks every result in order.
// A short directed run covers the control codes, ignored bytes, reads out
// of range, wrapping, scrolling and every way of clearing the screen; then
// three random phases with different idling on both channels follow.
// ----------------------------------------------------------------------------
module tb_top;
  import tcce_pkg::*;
  import tcce_tb_pkg::*;

  localparam int RESET_CYCLES   = 12;
  // Extra wait once every outstanding result has come back, so that the
  // engine is surely idle before the next step.
  localparam int DRAIN_CYCLES   = 32;
  localparam int PHASE_REQUESTS = 400;
  // The limit is several times what the run would need if every request
  // cleared the screen.
  localparam longint TIMEOUT_NS = 64'd200_000_000;

  localparam logic [PADDR_W-1:0] ATTR_ADDR   = {REG_TEXT_ATTR, 2'b00};
  // Word address with no register behind it; writes there must be ignored.
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = PADDR_W'(4);

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Percent chance that the sender pauses before a request, and percent of cycles in which the receiver holds back.
  int unsigned tx_idle_pct = 22;
  int unsigned rx_idle_pct = 68;

  console_scoreboard sb = new();

  tcce_in_if  item_ch ();
  tcce_out_if result_ch ();

  text_console_cursor_engine dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit: a hang anywhere ends here as a failure.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  // Receiver. Results are sampled at the edge where valid and ready are both
  // high; ready is then redrawn for the next cycle from the idle percentage.
  initial begin
    console_res_t got;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got.cursor_col     = result_ch.cursor_col;
        got.cursor_row     = result_ch.cursor_row;
        got.cursor_address = result_ch.cursor_address;
        got.cell_char      = result_ch.cell_char;
        got.cell_attr      = result_ch.cell_attr;
        got.scrolled       = result_ch.scrolled;
        sb.check_result(got);
      end
      result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic console_req_t make_req(opcode_t op, int unsigned ch, int unsigned idx,
                                            int unsigned col, int unsigned row);
    console_req_t r;
    r.opcode     = op;
    r.char_code  = CHAR_W'(ch);
    r.cell_index = INDEX_W'(idx);
    r.start_col  = START_W'(col);
    r.start_row  = START_W'(row);
    return r;
  endfunction

  // One random request. Fields that the opcode does not use still carry
  // random values, so every input bit toggles. Most traffic is printable
  // text and control codes; reads favor the rows near the cursor where text
  // was just written, and placements favor the bottom rows so that text
  // wraps into a scroll.
  function automatic console_req_t random_request();
    console_req_t r;
    int unsigned  pick;
    int unsigned  k;
    int unsigned  row_sel;
    r    = make_req(OP_PUT, $urandom_range(255), $urandom_range(2047),
                    $urandom_range(255), $urandom_range(255));
    pick = $urandom_range(99);
    k    = $urandom_range(99);
    if (pick < 65) begin
      r.opcode = OP_PUT;
      if (k < 60) begin
        r.char_code = CHAR_W'($urandom_range(PRINT_HI, PRINT_LO));
      end else if (k < 85) begin
        case ($urandom_range(3))
          0: r.char_code = CH_BACKSPACE;
          1: r.char_code = CH_TAB;
          2: r.char_code = CH_NEWLINE;
          default: r.char_code = CH_RETURN;
        endcase
      end else begin
        // Noise: any byte below the printable range (the control codes among
        // them) or above it.
        r.char_code = $urandom_range(1) ? CHAR_W'($urandom_range(255, PRINT_HI + 1))
                                        : CHAR_W'($urandom_range(PRINT_LO - 1));
      end
    end else if (pick < 80) begin
      r.opcode = OP_READ;
      if (k < 10) begin
        r.cell_index = INDEX_W'($urandom_range(2047, CELL_COUNT));
      end else if (k < 60) begin
        row_sel = (sb.cur_row > 0 && $urandom_range(1)) ? sb.cur_row - 1 : sb.cur_row;
        r.cell_index = INDEX_W'(row_sel * COLUMNS + $urandom_range(COLUMNS - 1));
      end else begin
        r.cell_index = INDEX_W'($urandom_range(CELL_COUNT - 1));
      end
    end else if (pick < 97) begin
      r.opcode = OP_START;
      if (k < 10) begin
        // The three ways of clearing the screen.
        case ($urandom_range(2))
          0: begin
            r.start_col = '0;
            r.start_row = '0;
          end
          1: r.start_col = START_W'($urandom_range(255, COLUMNS));
          default: r.start_row = START_W'($urandom_range(255, ROWS));
        endcase
      end else begin
        r.start_col = START_W'($urandom_range(COLUMNS - 1));
        r.start_row = (k < 40) ? START_W'($urandom_range(ROWS - 1, ROWS - 3))
                               : START_W'($urandom_range(ROWS - 1));
        if (r.start_col == 0 && r.start_row == 0) r.start_col = 1;
      end
    end else begin
      r.opcode = OP_SPARE;
    end
    return r;
  endfunction

  // Presents one request and returns at the edge where it is taken. A random
  // gap before it lowers valid first; without a gap valid simply stays high
  // and the payload changes, giving back-to-back requests.
  task automatic send_request(input console_req_t r);
    if ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.opcode     <= r.opcode;
    item_ch.char_code  <= r.char_code;
    item_ch.cell_index <= r.cell_index;
    item_ch.start_col  <= r.start_col;
    item_ch.start_row  <= r.start_row;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  // A well-formed burst: place the cursor, type a run of text, and end the
  // line with a newline, a return or a tab.
  task automatic send_text_line(output int unsigned count);
    int unsigned len;
    int unsigned row;
    row = $urandom_range(1) ? $urandom_range(ROWS - 1, ROWS - 3) : $urandom_range(ROWS - 1);
    send_request(make_req(OP_START, $urandom_range(255), $urandom_range(2047),
                          $urandom_range(COLUMNS - 1, 1), row));
    len = $urandom_range(40, 5);
    repeat (len) begin
      send_request(make_req(OP_PUT, $urandom_range(PRINT_HI, PRINT_LO), $urandom_range(2047),
                            $urandom_range(255), $urandom_range(255)));
    end
    case ($urandom_range(2))
      0: send_request(make_req(OP_PUT, CH_NEWLINE, 0, 0, 0));
      1: send_request(make_req(OP_PUT, CH_RETURN, 0, 0, 0));
      default: send_request(make_req(OP_PUT, CH_TAB, 0, 0, 0));
    endcase
    count = len + 2;
  endtask

  // Stops sending and waits until every outstanding request has its result,
  // then a little longer so the engine is surely idle.
  task automatic wait_for_results();
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Sets the text attribute. A write to the unused address goes first and
  // must leave the register alone; the read-back then checks both writes.
  task automatic set_text_attr(input logic [ATTR_W-1:0] value);
    logic [PDATA_W-1:0] readback;
    apb_write(UNUSED_ADDR, PDATA_W'(~value));
    apb_write(ATTR_ADDR, PDATA_W'(value));
    sb.set_attr(value);
    apb_read(ATTR_ADDR, readback);
    if (readback != PDATA_W'(value))
      sb.report($sformatf("text attribute reads %0h, expected %0h", readback, value));
  endtask

  initial begin
    console_req_t  directed_q[$];
    int unsigned   sent;
    int unsigned   burst;
    bit            paused;

    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    item_ch.valid      <= 1'b0;
    item_ch.opcode     <= OP_PUT;
    item_ch.char_code  <= '0;
    item_ch.cell_index <= '0;
    item_ch.start_col  <= '0;
    item_ch.start_row  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // The engine is still sweeping the screen with its reset blanks, but the
    // register port is live; the new attribute must not show up in that
    // sweep, only in what is written from here on.
    set_text_attr(8'hFF);

    // Directed part. The screen starts as blanks in the reset attribute, so
    // the first reads check the reset contents, including both ends of the
    // store and indexes past its end.
    directed_q.push_back(make_req(OP_READ, 0, 0, 0, 0));
    directed_q.push_back(make_req(OP_READ, 0, CELL_COUNT - 1, 0, 0));
    directed_q.push_back(make_req(OP_READ, 0, CELL_COUNT, 0, 0));
    directed_q.push_back(make_req(OP_READ, 0, 2047, 0, 0));
    // Both ends of the printable range, then bytes just outside it and the
    // byte extremes, all of which must leave the cursor alone.
    directed_q.push_back(make_req(OP_PUT, PRINT_HI, 0, 0, 0));
    directed_q.push_back(make_req(OP_PUT, PRINT_LO, 0, 0, 0));
    directed_q.push_back(make_req(OP_PUT, PRINT_LO - 1, 0, 0, 0));
    directed_q.push_back(make_req(OP_PUT, PRINT_HI + 1, 0, 0, 0));
    directed_q.push_back(make_req(OP_PUT, 0, 0, 0, 0));
    directed_q.push_back(make_req(OP_PUT, 255, 0, 0, 0));
    // Tab from column 2, backspace, return, and a backspace at column 0.
    directed_q.push_back(make_req(OP_PUT, CH_TAB, 0, 0, 0));
    directed_q.push_back(make_req(OP_PUT, CH_BACKSPACE, 0, 0, 0));
    directed_q.push_back(make_req(OP_PUT, CH_RETURN, 0, 0, 0));
    directed_q.push_back(make_req(OP_PUT, CH_BACKSPACE, 0, 0, 0));
    directed_q.push_back(make_req(OP_READ, 0, 0, 0, 0));
    // A character in the bottom right corner wraps and scrolls; it must then
    // be found one row up.
    directed_q.push_back(make_req(OP_START, 0, 0, COLUMNS - 1, ROWS - 1));
    directed_q.push_back(make_req(OP_PUT, 90, 0, 0, 0));
    directed_q.push_back(make_req(OP_READ, 0, (ROWS - 1) * COLUMNS - 1, 0, 0));
    // A tab from the last column and a newline on the last row both scroll.
    directed_q.push_back(make_req(OP_START, 0, 0, COLUMNS - 1, ROWS - 1));
    directed_q.push_back(make_req(OP_PUT, CH_TAB, 0, 0, 0));
    directed_q.push_back(make_req(OP_PUT, CH_NEWLINE, 0, 0, 0));
    // Every way of clearing: home position, column too large, row too large
    // and both at their maximum. Then the smallest real placement and the
    // unused opcode.
    directed_q.push_back(make_req(OP_START, 0, 0, 0, 0));
    directed_q.push_back(make_req(OP_START, 0, 0, COLUMNS, 0));
    directed_q.push_back(make_req(OP_START, 0, 0, 0, ROWS));
    directed_q.push_back(make_req(OP_START, 0, 0, 255, 255));
    directed_q.push_back(make_req(OP_START, 0, 0, 1, 0));
    directed_q.push_back(make_req(OP_SPARE, 0, 0, 0, 0));
    foreach (directed_q[i]) send_request(directed_q[i]);

    // Random phases: the sender idles lightly while the receiver stalls
    // hard, then the other way round, then both run flat out. Each phase
    // starts from an idle engine with a new attribute, the lowest one first.
    for (int phase = 0; phase < 3; phase++) begin
      wait_for_results();
      case (phase)
        0: begin
          tx_idle_pct = 22;
          rx_idle_pct = 68;
        end
        1: begin
          tx_idle_pct = 68;
          rx_idle_pct = 22;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      set_text_attr(phase == 0 ? 8'h00 : ATTR_W'($urandom));
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_REQUESTS) begin
        if ($urandom_range(99) < 12) begin
          send_text_line(burst);
          sent += burst;
        end else begin
          send_request(random_request());
          sent++;
        end
        // Halfway through, hold off until the engine has answered
        // everything, and change the attribute while it is idle.
        if (!paused && sent >= PHASE_REQUESTS / 2) begin
          paused = 1'b1;
          wait_for_results();
          set_text_attr(ATTR_W'($urandom));
        end
      end
    end

    wait_for_results();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_in_if.sv
hw/rtl/tcce_out_if.sv
hw/rtl/tcce_dpath.sv
hw/rtl/tcce_ctrl.sv
hw/rtl/text_console_cursor_engine.sv
test/tcce_tb_pkg.sv
test/tb_top.sv
